FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file bba_checker.sv.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Expression must hold at every rising clock edge outside reset.
`define BBA_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// Antecedent in one cycle implies the consequent in the next.
`define BBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: hdl/bba_pkg.sv
// Package of the buddy block allocator: field widths, codes, defaults.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;
    localparam int POOL_SIZE_DEF  = 1024;
    localparam int MIN_BLOCK_DEF  = 2;
    localparam int OWNER_BITS_DEF = 8;

    localparam int REQ_SIZE_W = 11;
    localparam int OWNER_ID_W = 8;
    localparam int STATUS_W   = 2;
    localparam int START_W    = 10;
    localparam int BSIZE_W    = 11;
    localparam int OWNER_EXT_W = 16;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_GRANTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FAIL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd2;
endpackage
`default_nettype wire

FILE: hdl/bba_if.sv
// Request and response channel interfaces of the buddy block allocator.
// Depends on bba_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface bba_req_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [bba_pkg::REQ_SIZE_W-1:0] request_size;
    logic [bba_pkg::OWNER_ID_W-1:0] owner_id;
    modport source (output valid, operation, request_size, owner_id, input ready);
    modport sink (input valid, operation, request_size, owner_id, output ready);
endinterface

interface bba_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bba_pkg::STATUS_W-1:0] status;
    logic [bba_pkg::START_W-1:0]  block_start;
    logic [bba_pkg::BSIZE_W-1:0]  block_size;
    modport source (output valid, status, block_start, block_size, input ready);
    modport sink (input valid, status, block_start, block_size, output ready);
endinterface
`default_nettype wire

FILE: hdl/bba_node_ram.sv
// Node store of the allocator tree: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module bba_node_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 10
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/buddy_block_allocator.sv
// Buddy block allocator top level: sequencer over the node store.
// Depends on bba_pkg, bba_if and bba_node_ram.
//
// Usage: requests arrive on the req channel (operation, request_size,
// owner_id) and each yields exactly one response on the rsp channel
// (status, block_start, block_size). Both use valid/ready; a request is
// taken when valid and ready are high at a rising edge.
// The tree of split/used/owner marks lives in one synchronous RAM, one node
// per entry, heap numbered from 1. The sequencer walks the tree one node
// access at a time: a node visit has an address state and then a data
// state, a step to a sibling or a parent has its own state, and a merge
// check reads the left buddy, then the right one, then decides. Allocation
// first rounds the size up by doubling, then visits nodes in address order,
// splits down to the rounded size and posts the response. A release visits
// every node down to the leaves and checks each split node for a merge.
// One request is worked on at a time.
// After reset the block clears the RAM, one entry per cycle, and holds
// req.ready low meanwhile.
// The response sits in an output register; a new request is taken while it
// waits, but a finished result waits for the register if rsp.ready is low.
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator #(
    parameter int POOL_SIZE  = bba_pkg::POOL_SIZE_DEF,
    parameter int MIN_BLOCK  = bba_pkg::MIN_BLOCK_DEF,
    parameter int OWNER_BITS = bba_pkg::OWNER_BITS_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    bba_req_if.sink   req,
    bba_rsp_if.source rsp
);
    localparam int NODE_COUNT = 2 * (POOL_SIZE / MIN_BLOCK) - 1;
    localparam int IDX_W      = $clog2(NODE_COUNT + 1);
    localparam int SIZE_W     = $clog2(POOL_SIZE) + 1;
    localparam int OFS_W      = SIZE_W - 1;
    localparam int ENT_W      = OWNER_BITS + 2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ROUND, S_SRD, S_SEV, S_SUP, S_SPLIT,
        S_RRD, S_REV, S_RFIN, S_MRDL, S_MRDR, S_MEV, S_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [SIZE_W-1:0]          size_reg, size_next;
    logic [SIZE_W-1:0]          need_reg, need_next;
    logic [OFS_W-1:0]           start_reg, start_next;
    logic [bba_pkg::REQ_SIZE_W-1:0] rsz_reg, rsz_next;
    logic [OWNER_BITS-1:0]      owner_reg, owner_next;
    logic                       lfree_reg, lfree_next;
    logic [IDX_W-1:0]           clr_reg, clr_next;
    logic [bba_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [bba_pkg::START_W-1:0]  res_start_reg, res_start_next;
    logic [bba_pkg::BSIZE_W-1:0]  res_size_reg, res_size_next;
    logic                       out_valid_reg, out_valid_next;
    logic [bba_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [bba_pkg::START_W-1:0]  out_start_reg, out_start_next;
    logic [bba_pkg::BSIZE_W-1:0]  out_size_reg, out_size_next;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr, ram_raddr;
    logic [ENT_W-1:0]       ram_wdata, ram_rdata;
    logic                   ent_split, ent_used;
    logic [OWNER_BITS-1:0]  ent_owner;
    logic [bba_pkg::OWNER_EXT_W-1:0] owner_ext;

    bba_node_ram #(
        .ADDR_W(IDX_W),
        .DATA_W(ENT_W)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign ent_split = ram_rdata[OWNER_BITS + 1];
    assign ent_used  = ram_rdata[OWNER_BITS];
    assign ent_owner = ram_rdata[OWNER_BITS-1:0];
    assign owner_ext = bba_pkg::OWNER_EXT_W'(req.owner_id);

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.block_start = out_start_reg;
    assign rsp.block_size  = out_size_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        size_next       = size_reg;
        need_next       = need_reg;
        start_next      = start_reg;
        rsz_next        = rsz_reg;
        owner_next      = owner_reg;
        lfree_next      = lfree_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_size_next   = res_size_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        out_size_next   = out_size_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = '0;
        ram_raddr       = idx_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // Zero every entry once after reset.
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(NODE_COUNT))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    rsz_next        = req.request_size;
                    owner_next      = owner_ext[OWNER_BITS-1:0];
                    idx_next        = IDX_W'(1);
                    size_next       = SIZE_W'(POOL_SIZE);
                    start_next      = '0;
                    need_next       = SIZE_W'(MIN_BLOCK);
                    res_status_next = bba_pkg::ST_FAIL;
                    res_start_next  = '0;
                    res_size_next   = '0;
                    if (req.operation == bba_pkg::OP_RELEASE)
                    begin
                        state_next = S_RRD;
                    end
                    else if (req.request_size == '0 ||
                             32'(req.request_size) > 32'(POOL_SIZE))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ROUND;
                    end
                end
            end
            S_ROUND:
            begin
                if (32'(need_reg) < 32'(rsz_reg))
                begin
                    need_next = {need_reg[SIZE_W-2:0], 1'b0};
                end
                else
                begin
                    state_next = S_SRD;
                end
            end
            S_SRD:
            begin
                state_next = S_SEV;
            end
            S_SEV:
            begin
                if (size_reg < need_reg)
                begin
                    state_next = S_SUP;
                end
                else if (ent_split && size_reg > SIZE_W'(MIN_BLOCK))
                begin
                    idx_next   = {idx_reg[IDX_W-2:0], 1'b0};
                    size_next  = size_reg >> 1;
                    state_next = S_SRD;
                end
                else if (!ent_used)
                begin
                    state_next = S_SPLIT;
                end
                else
                begin
                    state_next = S_SUP;
                end
            end
            S_SUP:
            begin
                // Move to the next subtree in address order, climbing as needed.
                if (idx_reg == IDX_W'(1))
                begin
                    state_next = S_DONE;
                end
                else if (idx_reg[0])
                begin
                    idx_next   = idx_reg >> 1;
                    start_next = start_reg - OFS_W'(size_reg);
                    size_next  = {size_reg[SIZE_W-2:0], 1'b0};
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    start_next = start_reg + OFS_W'(size_reg);
                    state_next = S_SRD;
                end
            end
            S_SPLIT:
            begin
                ram_we = 1'b1;
                if (size_reg > need_reg)
                begin
                    ram_wdata = {1'b1, 1'b0, {OWNER_BITS{1'b0}}};
                    idx_next  = {idx_reg[IDX_W-2:0], 1'b0};
                    size_next = size_reg >> 1;
                end
                else
                begin
                    ram_wdata       = {1'b0, 1'b1, owner_reg};
                    res_status_next = bba_pkg::ST_GRANTED;
                    res_start_next  = bba_pkg::START_W'(start_reg);
                    res_size_next   = bba_pkg::BSIZE_W'(size_reg);
                    state_next      = S_DONE;
                end
            end
            S_RRD:
            begin
                state_next = S_REV;
            end
            S_REV:
            begin
                if (ent_split && size_reg > SIZE_W'(MIN_BLOCK))
                begin
                    idx_next   = {idx_reg[IDX_W-2:0], 1'b0};
                    size_next  = size_reg >> 1;
                    state_next = S_RRD;
                end
                else
                begin
                    if (ent_used && ent_owner == owner_reg)
                    begin
                        ram_we = 1'b1;
                    end
                    state_next = S_RFIN;
                end
            end
            S_RFIN:
            begin
                if (idx_reg == IDX_W'(1))
                begin
                    res_status_next = bba_pkg::ST_RELEASED;
                    state_next      = S_DONE;
                end
                else if (!idx_reg[0])
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RRD;
                end
                else
                begin
                    idx_next   = idx_reg >> 1;
                    size_next  = {size_reg[SIZE_W-2:0], 1'b0};
                    state_next = S_MRDL;
                end
            end
            S_MRDL:
            begin
                ram_raddr  = {idx_reg[IDX_W-2:0], 1'b0};
                state_next = S_MRDR;
            end
            S_MRDR:
            begin
                ram_raddr  = {idx_reg[IDX_W-2:0], 1'b1};
                lfree_next = !ent_split && !ent_used;
                state_next = S_MEV;
            end
            S_MEV:
            begin
                // Both buddies free and whole: the parent becomes whole again.
                if (lfree_reg && !ent_split && !ent_used)
                begin
                    ram_we = 1'b1;
                end
                state_next = S_RFIN;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_start_next  = res_start_reg;
                    out_size_next   = res_size_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        size_reg       <= size_next;
        need_reg       <= need_next;
        start_reg      <= start_next;
        rsz_reg        <= rsz_next;
        owner_reg      <= owner_next;
        lfree_reg      <= lfree_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_size_reg   <= res_size_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
        out_size_reg   <= out_size_next;
    end
endmodule
`default_nettype wire

FILE: hdl/bba_checker.sv
// Port checker of the buddy block allocator, bound to the top level.
// Depends on bba_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bba_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [bba_pkg::STATUS_W-1:0]  status,
    input wire logic [bba_pkg::START_W-1:0]   block_start,
    input wire logic [bba_pkg::BSIZE_W-1:0]   block_size
);
    logic                         rsp_stall;
    logic                         grant_shown;
    logic                         other_shown;
    logic [bba_pkg::BSIZE_W-1:0]  start_ext;
    logic [bba_pkg::BSIZE_W-1:0]  size_mask;

    assign rsp_stall   = rsp_valid && !rsp_ready;
    assign grant_shown = rsp_valid && (status == bba_pkg::ST_GRANTED);
    assign other_shown = rsp_valid && (status != bba_pkg::ST_GRANTED);
    assign start_ext   = bba_pkg::BSIZE_W'(block_start);
    assign size_mask   = block_size - 1'b1;

    `BBA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_stall, rsp_valid && $stable(status))
    `BBA_ASSERT(a_grant_aligned, clk, rst_n, !grant_shown || (start_ext & size_mask) == '0)
    `BBA_ASSERT(a_grant_pow2, clk, rst_n, !grant_shown || $onehot(block_size))
    `BBA_ASSERT(a_other_zero, clk, rst_n, !other_shown || (block_start == '0 && block_size == '0))
endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .status     (rsp.status),
    .block_start(rsp.block_start),
    .block_size (rsp.block_size)
);
`default_nettype wire

FILE: tb/sv/tb_buddy_block_allocator.sv
// Testbench for the buddy block allocator: random and directed requests with a scoreboard.
// Depends on bba_pkg, bba_if and the buddy_block_allocator RTL.
`timescale 1ns / 1ps
module tb_buddy_block_allocator;
    localparam int POOL  = 1024;
    localparam int MINB  = 2;
    localparam int NODES = 2 * POOL / MINB - 1;

    typedef struct packed {
        logic [bba_pkg::STATUS_W-1:0] status;
        logic [bba_pkg::START_W-1:0]  block_start;
        logic [bba_pkg::BSIZE_W-1:0]  block_size;
    } alloc_result_t;

    // Scoreboard class: it holds its own copy of the buddy tree and the queue of
    // expected responses.
    class buddy_scoreboard;
        bit            split_mark [NODES+1];
        bit            used_mark  [NODES+1];
        bit [7:0]      owner_mark [NODES+1];
        alloc_result_t pending_results [$];
        int            error_count;
        int unsigned   hit_start;
        int unsigned   hit_size;

        // Returns the node of the first free unsplit block that is large enough, or 0.
        function automatic int unsigned find_free(int unsigned idx, int unsigned sz,
                                                  int unsigned st, int unsigned need);
            int unsigned hit;
            if (idx == 0 || idx > NODES || sz < need)
                return 0;
            if (split_mark[idx] && sz > MINB)
            begin
                hit = find_free(2 * idx, sz / 2, st, need);
                if (hit != 0)
                    return hit;
                return find_free(2 * idx + 1, sz / 2, st + sz / 2, need);
            end
            if (!used_mark[idx])
            begin
                hit_start = st;
                hit_size  = sz;
                return idx;
            end
            return 0;
        endfunction

        function automatic void free_owner(int unsigned idx, int unsigned sz, bit [7:0] own);
            int unsigned l;
            if (idx == 0 || idx > NODES)
                return;
            if (split_mark[idx] && sz > MINB)
            begin
                l = 2 * idx;
                free_owner(l, sz / 2, own);
                free_owner(l + 1, sz / 2, own);
                // Merge the buddies when both halves end up free and whole.
                if (!split_mark[l] && !used_mark[l] && !split_mark[l+1] && !used_mark[l+1])
                    split_mark[idx] = 0;
                return;
            end
            if (used_mark[idx] && owner_mark[idx] == own)
            begin
                used_mark[idx]  = 0;
                owner_mark[idx] = 0;
            end
        endfunction

        // Notes one accepted request and queues the response it should give.
        function void note_request(logic op, logic [bba_pkg::REQ_SIZE_W-1:0] rsz,
                                   logic [7:0] own);
            alloc_result_t r;
            int unsigned   need;
            int unsigned   idx;
            int unsigned   sz;
            r = '{status: bba_pkg::ST_FAIL, block_start: '0, block_size: '0};
            if (op == bba_pkg::OP_RELEASE)
            begin
                free_owner(1, POOL, own);
                r.status = bba_pkg::ST_RELEASED;
            end
            else if (rsz != 0 && rsz <= POOL)
            begin
                need = MINB;
                while (need < rsz)
                    need = need << 1;
                idx = find_free(1, POOL, 0, need);
                if (idx != 0)
                begin
                    sz = hit_size;
                    while (sz > need && 2 * idx + 1 <= NODES)
                    begin
                        split_mark[idx] = 1;
                        idx = 2 * idx;
                        sz  = sz / 2;
                    end
                    used_mark[idx]  = 1;
                    owner_mark[idx] = own;
                    r.status      = bba_pkg::ST_GRANTED;
                    r.block_start = hit_start[bba_pkg::START_W-1:0];
                    r.block_size  = sz[bba_pkg::BSIZE_W-1:0];
                end
            end
            pending_results.push_back(r);
        endfunction

        function void check_response(alloc_result_t got);
            alloc_result_t exp_r;
            if (pending_results.size() == 0)
            begin
                $display("%0t: response with none expected: %h", $realtime, got);
                error_count++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.status !== exp_r.status)
            begin
                $display("%0t: status expected %0d actual %0d", $realtime,
                         exp_r.status, got.status);
                error_count++;
            end
            if (got.block_start !== exp_r.block_start)
            begin
                $display("%0t: block_start expected %0d actual %0d", $realtime,
                         exp_r.block_start, got.block_start);
                error_count++;
            end
            if (got.block_size !== exp_r.block_size)
            begin
                $display("%0t: block_size expected %0d actual %0d", $realtime,
                         exp_r.block_size, got.block_size);
                error_count++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    buddy_block_allocator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    buddy_scoreboard sb;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Requests and responses are both sampled at the rising edge, before any
    // nonblocking update made at that edge takes effect.
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.operation, req_ch.request_size, req_ch.owner_id);
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response('{rsp_ch.status, rsp_ch.block_start, rsp_ch.block_size});
    end

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Sends one request: idles at random first, then holds valid until it is taken.
    // Valid drops after the request is taken and stays low until the next request.
    task automatic send_request(logic op, logic [bba_pkg::REQ_SIZE_W-1:0] rsz,
                                logic [7:0] own);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.operation    <= op;
        req_ch.request_size <= rsz;
        req_ch.owner_id     <= own;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        req_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random request: mostly allocations of small sizes, releases now and then
    // among a few owners so that the tree fills, splits and merges again.
    task automatic send_random;
        int unsigned sel;
        logic [bba_pkg::REQ_SIZE_W-1:0] rsz;
        sel = $urandom_range(99);
        if (sel < 22)
            send_request(bba_pkg::OP_RELEASE, bba_pkg::REQ_SIZE_W'($urandom),
                         8'($urandom_range(7)));
        else
        begin
            if (sel < 70)
                rsz = bba_pkg::REQ_SIZE_W'($urandom_range(1, 40));
            else if (sel < 90)
                rsz = bba_pkg::REQ_SIZE_W'($urandom_range(1, 300));
            else if (sel < 96)
                rsz = bba_pkg::REQ_SIZE_W'($urandom_range(1, 1024));
            else
                rsz = bba_pkg::REQ_SIZE_W'($urandom);
            send_request(bba_pkg::OP_ALLOC, rsz,
                         ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7)));
        end
    endtask

    task automatic drain;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.operation    = bba_pkg::OP_ALLOC;
        req_ch.request_size = '0;
        req_ch.owner_id     = '0;
        rsp_ch.ready        = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: bad sizes, size one, the whole pool, exhaustion,
        // owners at both ends of their range, and a release of an empty owner.
        send_request(bba_pkg::OP_ALLOC, 11'd0, 8'd1);
        send_request(bba_pkg::OP_ALLOC, 11'd1025, 8'd1);
        send_request(bba_pkg::OP_ALLOC, 11'h7FF, 8'd1);
        send_request(bba_pkg::OP_ALLOC, 11'd1024, 8'hFF);
        send_request(bba_pkg::OP_ALLOC, 11'd1, 8'd1);
        send_request(bba_pkg::OP_RELEASE, 11'h7FF, 8'hFF);
        send_request(bba_pkg::OP_ALLOC, 11'd1, 8'd0);
        send_request(bba_pkg::OP_ALLOC, 11'd2, 8'd0);
        send_request(bba_pkg::OP_ALLOC, 11'd3, 8'hAA);
        send_request(bba_pkg::OP_ALLOC, 11'd513, 8'h55);
        send_request(bba_pkg::OP_ALLOC, 11'd512, 8'h55);
        send_request(bba_pkg::OP_ALLOC, 11'd256, 8'd1);
        send_request(bba_pkg::OP_ALLOC, 11'd255, 8'd1);
        send_request(bba_pkg::OP_RELEASE, 11'd0, 8'd77);
        send_request(bba_pkg::OP_RELEASE, 11'd0, 8'h55);
        send_request(bba_pkg::OP_ALLOC, 11'd200, 8'd3);
        send_request(bba_pkg::OP_RELEASE, 11'd0, 8'd0);
        send_request(bba_pkg::OP_RELEASE, 11'd0, 8'hAA);
        send_request(bba_pkg::OP_RELEASE, 11'd0, 8'd1);
        send_request(bba_pkg::OP_RELEASE, 11'd0, 8'd3);
        send_request(bba_pkg::OP_ALLOC, 11'd1024, 8'd9);
        send_request(bba_pkg::OP_RELEASE, 11'd0, 8'd9);

        // The sender holds off here until every response has come back.
        drain();

        // Random part in idling phases: none, sender, receiver, both.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 70 : (ph == 3) ? 22 : 0;
            recv_stall_pct = (ph == 2) ? 70 : (ph == 3) ? 22 : 0;
            for (int n = 0; n < 130; n++)
                send_random();
        end
        for (int own = 0; own < 8; own++)
            send_request(bba_pkg::OP_RELEASE, '0, 8'(own));

        drain();
        repeat (200) @(posedge clk);
        if (sb.error_count == 0 && sb.pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Even if every request took as long as the slowest possible one, the run
    // would end well inside this bound.
    initial
    begin
        #200ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hdl
hdl/bba_pkg.sv
hdl/bba_if.sv
hdl/bba_node_ram.sv
hdl/buddy_block_allocator.sv
hdl/bba_checker.sv
tb/sv/tb_buddy_block_allocator.sv
